// ===== hdl/stt_pkg.sv =====
// Shared types and codes for the software timer table.
// Used by the sequencer, the output register and the top level.
`timescale 1ns / 1ps

package stt_pkg;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_STOP  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_NONE  = 2'd3
  } req_e_t;

  typedef enum logic [1:0] {
    KIND_START  = 2'd0,
    KIND_STOP   = 2'd1,
    KIND_EXPIRY = 2'd2,
    KIND_DONE   = 2'd3
  } kind_e_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_OWNER  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_SCAN  = 2'd1,
    S_REPLY = 2'd2
  } seq_state_t;

  localparam logic [31:0] INVALID_ID = 32'hFFFF_FFFF;

  // One table entry as it is kept in the slot memory.
  typedef struct packed {
    logic [31:0] id;
    logic [15:0] owner;
    logic [31:0] tag;
    logic [47:0] interval;
    logic [47:0] remaining;
    logic        periodic;
  } entry_t;

  // One result item on its way to the output register.
  typedef struct packed {
    kind_e_t     kind;
    status_e_t   status;
    logic [31:0] timer_id;
    logic [15:0] owner_id;
    logic [31:0] tag;
    logic        last;
  } result_t;

endpackage

// ===== hdl/stt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/stt_obuf.sv =====
// Single-entry output register for result items.
// Depends on stt_pkg for the result item type.
`timescale 1ns / 1ps

module stt_obuf
  import stt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t item,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_item
);

  logic    valid_r;
  result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= item;
    end
  end

  assign can_push  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_item  = data_r;

endmodule

// ===== hdl/stt_seq.sv =====
// Request sequencer for start, stop and tick: walks the slot memory one entry
// per cycle, bar output stalls. Depends on stt_pkg; drives stt_ram, stt_obuf.
`timescale 1ns / 1ps

module stt_seq
  import stt_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_valid,
  output logic                                               in_stall,
  input  logic [1:0]                                         in_req_type,
  input  logic                                               in_owner_present,
  input  logic [15:0]                                        in_owner_id,
  input  logic [47:0]                                        in_interval_ns,
  input  logic                                               in_periodic,
  input  logic [31:0]                                        in_user_tag,
  input  logic [31:0]                                        in_timer_id,
  input  logic [31:0]                                        in_tick_ns,
  output logic                                               ram_we,
  output logic [(TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1)-1:0] ram_waddr,
  output entry_t                                             ram_wdata,
  output logic [(TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1)-1:0] ram_raddr,
  input  entry_t                                             ram_rdata,
  output logic                                               push,
  output result_t                                            item,
  input  logic                                               can_push
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

  seq_state_t              state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [TIMER_SLOTS-1:0]  valid_r, valid_nxt;
  logic [31:0]             next_id_r, next_id_nxt;
  kind_e_t                 rep_kind_r, rep_kind_nxt;
  status_e_t               rep_status_r, rep_status_nxt;
  logic [31:0]             rep_id_r, rep_id_nxt;

  req_e_t                  req_r;
  logic [15:0]             owner_r;
  logic [47:0]             interval_r;
  logic                    per_r;
  logic [31:0]             tag_r;
  logic [31:0]             tid_r;
  logic [31:0]             tick_r;

  logic                    accept;
  logic                    advance;
  logic                    last_slot;
  logic                    rem_gt;
  logic [47:0]             new_rem;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign last_slot = (idx_r == LAST_IDX);
  assign rem_gt    = ram_rdata.remaining > {16'd0, tick_r};
  assign new_rem   = rem_gt ? (ram_rdata.remaining - {16'd0, tick_r}) : 48'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      valid_r   <= '0;
      next_id_r <= 32'd0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      valid_r   <= valid_nxt;
      next_id_r <= next_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rep_kind_r   <= rep_kind_nxt;
    rep_status_r <= rep_status_nxt;
    rep_id_r     <= rep_id_nxt;
    if (accept) begin
      req_r      <= req_e_t'(in_req_type);
      owner_r    <= in_owner_id;
      interval_r <= in_interval_ns;
      per_r      <= in_periodic;
      tag_r      <= in_user_tag;
      tid_r      <= in_timer_id;
      tick_r     <= in_tick_ns;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    valid_nxt      = valid_r;
    next_id_nxt    = next_id_r;
    rep_kind_nxt   = rep_kind_r;
    rep_status_nxt = rep_status_r;
    rep_id_nxt     = rep_id_r;
    advance        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = ram_rdata;
    push           = 1'b0;
    item           = '{kind: KIND_EXPIRY, status: ST_OK, timer_id: ram_rdata.id,
                       owner_id: ram_rdata.owner, tag: ram_rdata.tag, last: 1'b0};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt = '0;
          priority case (req_e_t'(in_req_type))
            REQ_START: begin
              if (!in_owner_present) begin
                rep_kind_nxt   = KIND_START;
                rep_status_nxt = ST_NO_OWNER;
                rep_id_nxt     = INVALID_ID;
                state_nxt      = S_REPLY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            REQ_STOP: begin
              if (!in_owner_present) begin
                rep_kind_nxt   = KIND_STOP;
                rep_status_nxt = ST_NO_OWNER;
                rep_id_nxt     = in_timer_id;
                state_nxt      = S_REPLY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            REQ_TICK: state_nxt = S_SCAN;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end

      S_SCAN: begin
        unique case (req_r)
          REQ_START: begin
            if (!valid_r[idx_r]) begin
              ram_we             = 1'b1;
              ram_wdata          = '{id: next_id_r, owner: owner_r, tag: tag_r,
                                     interval: interval_r, remaining: interval_r,
                                     periodic: per_r};
              valid_nxt[idx_r]   = 1'b1;
              rep_kind_nxt       = KIND_START;
              rep_status_nxt     = ST_OK;
              rep_id_nxt         = next_id_r;
              next_id_nxt        = next_id_r + 32'd1;
              state_nxt          = S_REPLY;
            end else if (last_slot) begin
              rep_kind_nxt   = KIND_START;
              rep_status_nxt = ST_FULL;
              rep_id_nxt     = INVALID_ID;
              state_nxt      = S_REPLY;
            end else begin
              advance = 1'b1;
            end
          end
          REQ_STOP: begin
            if (valid_r[idx_r] && ram_rdata.id == tid_r && ram_rdata.owner == owner_r) begin
              valid_nxt[idx_r] = 1'b0;
              rep_kind_nxt     = KIND_STOP;
              rep_status_nxt   = ST_OK;
              rep_id_nxt       = tid_r;
              state_nxt        = S_REPLY;
            end else if (last_slot) begin
              rep_kind_nxt   = KIND_STOP;
              rep_status_nxt = ST_NOT_FOUND;
              rep_id_nxt     = tid_r;
              state_nxt      = S_REPLY;
            end else begin
              advance = 1'b1;
            end
          end
          REQ_TICK: begin
            // A slot that expires holds the scan until the output can take it.
            logic move;
            move = 1'b1;
            if (valid_r[idx_r]) begin
              if (new_rem == 48'd0) begin
                if (can_push) begin
                  push                = 1'b1;
                  ram_we              = 1'b1;
                  ram_wdata.remaining = ram_rdata.periodic ? ram_rdata.interval : 48'd0;
                  if (!ram_rdata.periodic) begin
                    valid_nxt[idx_r] = 1'b0;
                  end
                end else begin
                  move = 1'b0;
                end
              end else begin
                ram_we              = 1'b1;
                ram_wdata.remaining = new_rem;
              end
            end
            if (move) begin
              if (last_slot) begin
                rep_kind_nxt   = KIND_DONE;
                rep_status_nxt = ST_OK;
                rep_id_nxt     = 32'd0;
                state_nxt      = S_REPLY;
              end else begin
                advance = 1'b1;
              end
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_REPLY: begin
        item = '{kind: rep_kind_r, status: rep_status_r, timer_id: rep_id_r,
                 owner_id: 16'd0, tag: 32'd0, last: 1'b1};
        if (can_push) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (advance) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  // Read the next slot while the current one is evaluated; hold it on a stall.
  always_comb begin
    if (advance) begin
      ram_raddr = idx_r + IDX_W'(1);
    end else if (state_r == S_SCAN) begin
      ram_raddr = idx_r;
    end else begin
      ram_raddr = '0;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("result pushed while the output register is full");

  a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_SCAN))
    else $error("slot memory written outside a scan");

  a_id_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == S_SCAN && req_r == REQ_START)
      |=> (next_id_r == $past(next_id_r) + 32'd1) && valid_r[$past(idx_r)])
    else $error("start did not claim its slot or advance the id");

  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push && state_r == S_REPLY) |-> (item.last && state_nxt == S_IDLE))
    else $error("closing result item without last");

endmodule

// ===== hdl/software_timer_table_core.sv =====
// Top level of the software timer table: request sequencer, slot memory and
// output register. Depends on stt_pkg, stt_ram, stt_obuf and stt_seq.
`timescale 1ns / 1ps

// The block keeps TIMER_SLOTS software timers and serves one request at a
// time. A start request claims the lowest free slot, tags it with the next id
// from a wrapping 32-bit counter and replies with that id; it is refused with
// "no owner" or "table full" and an id of all ones. A stop request frees the
// lowest slot whose id and owner both match, or replies "not found", or "no
// owner" when no owner is given. A tick request lowers every live count by
// the tick, saturating at zero, emits one expiry item per timer that reaches
// zero in slot order, reloads periodic timers, frees one-shot timers, and
// closes with a "tick done" item that has last set. Every request but an
// unknown one ends with exactly one item that has last set; an unknown request
// type is dropped without a result. The slot fields live in one synchronous
// memory read one entry per cycle, while the slot valid bits sit in flip-flops
// that reset clears, so no clearing pass is needed after reset. A tick walks
// every slot in turn, then hands the closing item to the output register and
// returns to idle; a result item, expiry or closing, that waits on a full
// output register holds the sequencer. A start or stop ends its walk at the
// free or matching slot or at the last slot, a refused request without an
// owner goes straight to its reply, and an unknown request leaves the
// sequencer idle. The input is stalled while a request is in flight; the
// output register lets the next request be accepted while the previous
// closing item still waits to be taken.
module software_timer_table_core
  import stt_pkg::*;
#(
  parameter int TIMER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic        in_owner_present,
  input  logic [15:0] in_owner_id,
  input  logic [47:0] in_interval_ns,
  input  logic        in_periodic,
  input  logic [31:0] in_user_tag,
  input  logic [31:0] in_timer_id,
  input  logic [31:0] in_tick_ns,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_result_kind,
  output logic [1:0]  out_status,
  output logic [31:0] out_timer_id,
  output logic [15:0] out_owner_id,
  output logic [31:0] out_tag,
  output logic        out_last
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  // Slot memory port signals.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_wdata;
  entry_t           ram_rdata;

  // Result items from the sequencer to the output register.
  logic             push;
  logic             can_push;
  result_t          item;
  result_t          out_item;

  stt_seq #(
    .TIMER_SLOTS(TIMER_SLOTS)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_owner_present (in_owner_present),
    .in_owner_id      (in_owner_id),
    .in_interval_ns   (in_interval_ns),
    .in_periodic      (in_periodic),
    .in_user_tag      (in_user_tag),
    .in_timer_id      (in_timer_id),
    .in_tick_ns       (in_tick_ns),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .ram_rdata        (ram_rdata),
    .push             (push),
    .item             (item),
    .can_push         (can_push)
  );

  // Slot fields but the valid bits share one entry, read and written whole.
  stt_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TIMER_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The output register decouples result delivery from the memory scan.
  stt_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .item      (item),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign out_result_kind = out_item.kind;
  assign out_status      = out_item.status;
  assign out_timer_id    = out_item.timer_id;
  assign out_owner_id    = out_item.owner_id;
  assign out_tag         = out_item.tag;
  assign out_last        = out_item.last;

endmodule
